/* rtl/blp_pkg.sv */
`timescale 1ns / 1ps
package blp_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_RUN    = 64;
  localparam int RUN_BITS   = $clog2(MAX_RUN);
  localparam int ERR_BITS   = RUN_BITS + 3;
  localparam int CFG_BITS   = 7;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_BITS-1:0] MAX_POINTS_RST = CFG_BITS'(64);
  localparam logic [CFG_BITS-1:0] RUN_LIMIT      = CFG_BITS'(MAX_RUN);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t              x;
    coord_t              y;
    logic                x_neg;
    logic                y_neg;
    logic                x_major;
    logic [RUN_BITS-1:0] major;
    logic [RUN_BITS-1:0] minor;
    logic                reject;
  } line_cmd_t;

endpackage

/* rtl/blp_front.sv */
`timescale 1ns / 1ps
module blp_front
  import blp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  coord_t              in_x_start,
  input  coord_t              in_y_start,
  input  coord_t              in_x_end,
  input  coord_t              in_y_end,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_max_points,
  output logic                cmd_push,
  output line_cmd_t           cmd_data,
  input  logic                cmd_full
);

  logic [CFG_BITS-1:0]   max_points_r;
  logic                  in_vld_r;
  logic                  in_vld_nxt;
  logic                  accept;
  coord_t                xs_r, ys_r, xe_r, ye_r;
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0] dx_neg, dy_neg;
  logic [COORD_BITS-1:0] adx, ady, major, minor;
  logic [CFG_BITS-1:0]   limit;
  logic                  x_major;

  assign cfg_ready  = 1'b1;
  assign accept     = in_push & ~in_full;
  assign in_full    = in_vld_r & cmd_full;
  assign cmd_push   = in_vld_r & ~cmd_full;
  assign in_vld_nxt = accept | (in_vld_r & cmd_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_points_r <= MAX_POINTS_RST;
      in_vld_r     <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        max_points_r <= cfg_max_points;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xs_r <= in_x_start;
      ys_r <= in_y_start;
      xe_r <= in_x_end;
      ye_r <= in_y_end;
    end
  end

  always_comb begin
    dx      = {xe_r[COORD_BITS-1], xe_r} - {xs_r[COORD_BITS-1], xs_r};
    dy      = {ye_r[COORD_BITS-1], ye_r} - {ys_r[COORD_BITS-1], ys_r};
    dx_neg  = -dx[COORD_BITS-1:0];
    dy_neg  = -dy[COORD_BITS-1:0];
    adx     = dx[COORD_BITS] ? dx_neg : dx[COORD_BITS-1:0];
    ady     = dy[COORD_BITS] ? dy_neg : dy[COORD_BITS-1:0];
    x_major = adx > ady;
    major   = x_major ? adx : ady;
    minor   = x_major ? ady : adx;
    limit   = (max_points_r > RUN_LIMIT) ? RUN_LIMIT : max_points_r;

    cmd_data.x       = xs_r;
    cmd_data.y       = ys_r;
    cmd_data.x_neg   = dx[COORD_BITS];
    cmd_data.y_neg   = dy[COORD_BITS];
    cmd_data.x_major = x_major;
    cmd_data.major   = major[RUN_BITS-1:0];
    cmd_data.minor   = minor[RUN_BITS-1:0];
    cmd_data.reject  = major >= {{(COORD_BITS-CFG_BITS){1'b0}}, limit};
  end

endmodule

/* rtl/blp_cmd_fifo.sv */
`timescale 1ns / 1ps
module blp_cmd_fifo
  import blp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  line_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output line_cmd_t pop_data,
  output logic      empty
);

  line_cmd_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               do_push, do_pop;

  assign full     = count_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/blp_stepper.sv */
`timescale 1ns / 1ps
module blp_stepper
  import blp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  input  line_cmd_t cmd_data,
  output logic      cmd_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output coord_t    out_point_x,
  output coord_t    out_point_y,
  output logic      out_last_point,
  output logic      out_rejected
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                       state_r, state_nxt;
  coord_t                     x_r, y_r, x_nxt, y_nxt;
  logic                       x_neg_r, y_neg_r, x_major_r, reject_r;
  logic [RUN_BITS-1:0]        major_r, minor_r, cnt_r;
  logic signed [ERR_BITS-1:0] err_r, err_nxt, err_add;
  logic                       out_vld_r;
  logic                       emit, last;
  coord_t                     x_step, y_step;

  assign cmd_pop   = (state_r == ST_IDLE) & ~cmd_empty;
  assign emit      = (state_r == ST_RUN) & (~out_vld_r | out_pop);
  assign last      = reject_r | (cnt_r == '0);
  assign out_empty = ~out_vld_r;

  always_comb begin
    x_step  = x_neg_r ? x_r - 1'b1 : x_r + 1'b1;
    y_step  = y_neg_r ? y_r - 1'b1 : y_r + 1'b1;
    err_add = err_r + $signed({2'b00, minor_r, 1'b0});
    x_nxt   = x_r;
    y_nxt   = y_r;
    err_nxt = err_add;
    if (x_major_r) begin
      x_nxt = x_step;
    end else begin
      y_nxt = y_step;
    end
    if (!err_add[ERR_BITS-1]) begin
      err_nxt = err_add - $signed({2'b00, major_r, 1'b0});
      if (x_major_r) begin
        y_nxt = y_step;
      end else begin
        x_nxt = x_step;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit && last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      x_r       <= cmd_data.x;
      y_r       <= cmd_data.y;
      x_neg_r   <= cmd_data.x_neg;
      y_neg_r   <= cmd_data.y_neg;
      x_major_r <= cmd_data.x_major;
      major_r   <= cmd_data.major;
      minor_r   <= cmd_data.minor;
      reject_r  <= cmd_data.reject;
      cnt_r     <= cmd_data.major;
      err_r     <= -$signed({3'b000, cmd_data.major});
    end else if (emit) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_point_x    <= reject_r ? '0 : x_r;
      out_point_y    <= reject_r ? '0 : y_r;
      out_last_point <= last;
      out_rejected   <= reject_r;
    end
  end

endmodule

/* rtl/bresenham_line_points.sv */
`timescale 1ns / 1ps
// bresenham line rasterizer: each input word is a segment (start and end point);
// the block returns every point from start to end, one result word per point, the
// last one flagged. a segment whose major length reaches the smaller of
// max_points and 64 gives a single word with rejected set and zero coordinates.
// the front stage registers a segment, computes lengths and direction from
// it and hands it to a two-entry command queue; the stepper then loads the
// segment and emits its points one by one, and loads no new segment until
// the last word of the current one is out. the stepper stalls while a finished
// word waits unpopped in the result register and moves on in the cycle it is
// popped.
module bresenham_line_points
  import blp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  coord_t              in_x_start,
  input  coord_t              in_y_start,
  input  coord_t              in_x_end,
  input  coord_t              in_y_end,
  output logic                out_empty,
  input  logic                out_pop,
  output coord_t              out_point_x,
  output coord_t              out_point_y,
  output logic                out_last_point,
  output logic                out_rejected,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_max_points
);

  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  line_cmd_t cmd_in, cmd_out;

  blp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_points (cfg_max_points),
    .cmd_push       (cmd_push),
    .cmd_data       (cmd_in),
    .cmd_full       (cmd_full)
  );

  blp_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  blp_stepper u_stepper (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_empty      (cmd_empty),
    .cmd_data       (cmd_out),
    .cmd_pop        (cmd_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point),
    .out_rejected   (out_rejected)
  );

endmodule

/* dv/bresenham_line_points_test.sv */
`timescale 1ns / 1ps
module bresenham_line_points_test;
  import blp_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_WAIT = 100;

  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   last;
    logic   rej;
  } point_word_t;

  typedef struct packed {
    coord_t      xs;
    coord_t      ys;
    coord_t      xe;
    coord_t      ye;
    logic        typed;
    point_word_t want;
  } segment_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  coord_t              in_x_start;
  coord_t              in_y_start;
  coord_t              in_x_end;
  coord_t              in_y_end;
  logic                out_empty;
  logic                out_pop;
  coord_t              out_point_x;
  coord_t              out_point_y;
  logic                out_last_point;
  logic                out_rejected;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_max_points;

  point_word_t         pending_points [$];
  point_word_t         head_word;
  point_word_t         typed_word;
  logic                use_typed;
  logic [CFG_BITS-1:0] point_limit_reg = 7'd64;
  int                  fail_count = 0;
  int                  idle_cycles = 0;
  int                  sink_gap = 0;
  bit                  hold_req = 1'b0;
  bit                  calm = 1'b0;

  // single points and rejects typed in, the rest traced by the predictor
  segment_row_t directed_rows [0:21] = '{
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, '{16'sh0000, 16'sh0000, 1'b1, 1'b0}},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, '{16'sh8000, 16'sh8000, 1'b1, 1'b0}},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, '{16'sh7fff, 16'sh7fff, 1'b1, 1'b0}},
    '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1, '{16'sh0000, 16'sh0000, 1'b1, 1'b1}},
    '{16'sh7fff, 16'sh0000, 16'sh8000, 16'sh0000, 1'b1, '{16'sh0000, 16'sh0000, 1'b1, 1'b1}},
    '{16'sh0000, 16'sh0000, 16'sh0040, 16'sh0000, 1'b1, '{16'sh0000, 16'sh0000, 1'b1, 1'b1}},
    '{16'sh0000, 16'sh0000, 16'sh0000, -16'sh0040, 1'b1, '{16'sh0000, 16'sh0000, 1'b1, 1'b1}},
    '{16'sh0000, 16'sh0000, 16'sh003f, 16'sh000a, 1'b0, '0},
    '{16'sh0005, -16'sh0005, -16'sh0014, 16'sh003a, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 16'sh0007, 16'sh0007, 1'b0, '0},
    '{16'sh0000, 16'sh0000, -16'sh0007, 16'sh0007, 1'b0, '0},
    '{16'sh0003, 16'sh0003, -16'sh0004, -16'sh0004, 1'b0, '0},
    '{16'sh000a, 16'sh000a, -16'sh0014, 16'sh0003, 1'b0, '0},
    '{-16'sh0003, 16'sh0004, 16'sh0005, -16'sh0009, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 16'sh000c, 16'sh0000, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 16'sh0000, -16'sh000c, 1'b0, '0},
    '{16'sh7ff8, 16'sh8000, 16'sh7fff, 16'sh8008, 1'b0, '0},
    '{16'sh8000, 16'sh7fff, 16'sh801c, 16'sh7ffa, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 16'sh0028, -16'sh0011, 1'b0, '0},
    '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 16'sh0002, 16'sh0001, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 16'sh0001, 16'sh0002, 1'b0, '0}
  };

  bresenham_line_points uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point),
    .out_rejected   (out_rejected),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_points (cfg_max_points)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int run_cap();
    return (point_limit_reg > 7'd64) ? 64 : int'(point_limit_reg);
  endfunction

  function automatic void trace_segment(input coord_t xs, ys, xe, ye);
    int          x, y, dx, dy, sx, sy, major, minor, err, n;
    bit          x_major;
    point_word_t w;
    x = int'(xs);
    y = int'(ys);
    dx = int'(xe) - x;
    dy = int'(ye) - y;
    sx = 1;
    sy = 1;
    if (dx < 0) begin
      dx = -dx;
      sx = -1;
    end
    if (dy < 0) begin
      dy = -dy;
      sy = -1;
    end
    x_major = dx > dy;
    major = x_major ? dx : dy;
    minor = x_major ? dy : dx;
    if (major >= run_cap()) begin
      w = '{16'sh0000, 16'sh0000, 1'b1, 1'b1};
      pending_points.push_back(w);
      return;
    end
    n = major + 1;
    err = -major;
    for (int k = 0; k < n; k++) begin
      w = '{coord_t'(x), coord_t'(y), (k == n - 1), 1'b0};
      pending_points.push_back(w);
      if (x_major) x += sx;
      else y += sy;
      err += 2 * minor;
      if (err >= 0) begin
        if (x_major) y += sy;
        else x += sx;
        err -= 2 * major;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (pending_points.size() == 0) begin
          $error("unexpected word: point_x %0d point_y %0d last %0b rejected %0b",
                 out_point_x, out_point_y, out_last_point, out_rejected);
          fail_count++;
        end else begin
          head_word = pending_points.pop_front();
          if (out_point_x !== head_word.px) begin
            $error("point_x: expected %0d, got %0d", head_word.px, out_point_x);
            fail_count++;
          end
          if (out_point_y !== head_word.py) begin
            $error("point_y: expected %0d, got %0d", head_word.py, out_point_y);
            fail_count++;
          end
          if (out_last_point !== head_word.last) begin
            $error("last_point: expected %0b, got %0b", head_word.last, out_last_point);
            fail_count++;
          end
          if (out_rejected !== head_word.rej) begin
            $error("rejected: expected %0b, got %0b", head_word.rej, out_rejected);
            fail_count++;
          end
        end
      end
      if (in_push && !in_full) begin
        if (use_typed) pending_points.push_back(typed_word);
        else trace_segment(in_x_start, in_y_start, in_x_end, in_y_end);
      end
      if ((out_pop && !out_empty) || (in_push && !in_full) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        sink_gap = LONG_HOLD;
        hold_req = 1'b0;
      end else if (sink_gap == 0 && !calm && $urandom_range(0, 11) == 0) begin
        sink_gap = $urandom_range(1, 17);
      end
      if (sink_gap > 0) begin
        out_pop <= 1'b0;
        sink_gap--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic drive_line(input coord_t xs, ys, xe, ye, input logic typed,
                            input point_word_t want);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_push    <= 1'b1;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end   <= xe;
    in_y_end   <= ye;
    use_typed  <= typed;
    typed_word <= want;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_points(input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_max_points <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    point_limit_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_BITS-1:0] value, input int count,
                           input bit long_hold, input bit quiet);
    coord_t xs, ys, xe, ye;
    int     pick, span, major, minor, dxv, dyv;
    write_max_points(value);
    calm = quiet;
    if (long_hold) hold_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      xs = coord_t'($urandom);
      ys = coord_t'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        xe = coord_t'($urandom);
        ye = coord_t'($urandom);
      end else if (pick == 1) begin
        xe = xs;
        ye = ys;
      end else begin
        span = ($urandom_range(0, 3) == 0 || run_cap() < 12) ? run_cap() : 12;
        major = $urandom_range(0, span);
        minor = $urandom_range(0, major);
        if ($urandom_range(0, 1)) begin
          dxv = major;
          dyv = minor;
        end else begin
          dxv = minor;
          dyv = major;
        end
        if ($urandom_range(0, 1)) dxv = -dxv;
        if ($urandom_range(0, 1)) dyv = -dyv;
        xe = coord_t'(int'(xs) + dxv);
        ye = coord_t'(int'(ys) + dyv);
      end
      drive_line(xs, ys, xe, ye, 1'b0, '0);
    end
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_x_start     = '0;
    in_y_start     = '0;
    in_x_end       = '0;
    in_y_end       = '0;
    use_typed      = 1'b0;
    typed_word     = '0;
    cfg_valid      = 1'b0;
    cfg_max_points = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset value of max_points in effect
    for (int i = 0; i < 22; i++) begin
      drive_line(directed_rows[i].xs, directed_rows[i].ys, directed_rows[i].xe,
                 directed_rows[i].ye, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_drained();

    run_phase(7'd0, 15, 1'b0, 1'b0);
    run_phase(7'd1, 20, 1'b0, 1'b0);
    run_phase(7'd127, 50, 1'b1, 1'b0);
    run_phase(7'd65, 30, 1'b0, 1'b0);
    run_phase(7'd10, 40, 1'b0, 1'b0);
    run_phase(7'($urandom_range(2, 63)), 40, 1'b0, 1'b0);
    run_phase(7'd64, 50, 1'b0, 1'b1);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
